### src/feature_range_outlier_check_core_defines.svh
// Assertion macros for the checker file.
`ifndef FEATURE_RANGE_OUTLIER_CHECK_CORE_DEFINES_SVH
`define FEATURE_RANGE_OUTLIER_CHECK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define FRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define FRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/frc_pkg.sv
package frc_pkg;

  localparam int FEATURES_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int OPCODE_W = 2;
  localparam int INDEX_W  = 6;
  localparam int SAMPLE_W = 32;
  localparam int COUNT_W  = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CHECK   = 2'd0,
    OP_UPDATE  = 2'd1,
    OP_LOAD_LO = 2'd2,
    OP_LOAD_HI = 2'd3
  } opcode_t;

  // Write enables for the lower and upper bound tables.
  typedef struct packed {
    logic lo_we;
    logic hi_we;
  } bound_wr_t;

endpackage

### src/frc_in_if.sv
interface frc_in_if import frc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [INDEX_W-1:0]         feature_index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       last_element;

  modport source (output valid, opcode, feature_index, sample_value, last_element,
                  input ready);
  modport sink   (input valid, opcode, feature_index, sample_value, last_element,
                  output ready);
endinterface

### src/frc_out_if.sv
interface frc_out_if import frc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               in_range;
  logic [COUNT_W-1:0] vectors_checked;
  logic [COUNT_W-1:0] outlier_vectors;
  logic [COUNT_W-1:0] elements_checked;

  modport source (output valid, in_range, vectors_checked, outlier_vectors, elements_checked,
                  input ready);
  modport sink   (input valid, in_range, vectors_checked, outlier_vectors, elements_checked,
                  output ready);
endinterface

### src/frc_cfg_if.sv
interface frc_cfg_if ();
  logic valid;
  logic ready;
  logic enabled;

  modport source (output valid, enabled, input ready);
  modport sink   (input valid, enabled, output ready);
endinterface

### src/frc_bound_mem.sv
module frc_bound_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [WIDTH-1:0]  rd_q_r;
  logic [ADDR_W-1:0] rd_addr_r;
  logic              byp_valid_r;
  logic [ADDR_W-1:0] byp_addr_r;
  logic [WIDTH-1:0]  byp_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // The most recent write is kept so that a read issued in the same cycle
  // still sees the newest value of its entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (wr_en) begin
      byp_valid_r <= 1'b1;
    end
    if (wr_en) begin
      byp_addr_r <= wr_addr;
      byp_data_r <= wr_data;
    end
  end

  assign rd_data = (byp_valid_r && (byp_addr_r == rd_addr_r)) ? byp_data_r : rd_q_r;

endmodule

### src/frc_judge.sv
module frc_judge import frc_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enabled,
  input  logic                          s1_valid,
  input  opcode_t                       s1_op,
  input  logic                          s1_last,
  input  logic                          s1_idx_ok,
  input  logic signed [VALUE_WIDTH-1:0] s1_val,
  input  logic signed [VALUE_WIDTH-1:0] lo,
  input  logic signed [VALUE_WIDTH-1:0] hi,
  output logic                          advance,
  output bound_wr_t                     wr,
  frc_out_if.source                     out_ch
);

  logic               vf_r, vf_nxt;
  logic [COUNT_W-1:0] vec_r, vec_nxt;
  logic [COUNT_W-1:0] outl_r, outl_nxt;
  logic [COUNT_W-1:0] elem_r, elem_nxt;
  logic               out_valid_r;
  logic               in_range_r;
  logic [COUNT_W-1:0] vec_out_r, outl_out_r, elem_out_r;

  logic is_check, emits, below, above, fail, vf_acc, check_fire;

  always_comb begin
    is_check   = (s1_op == OP_CHECK);
    emits      = is_check && s1_last;
    advance    = s1_valid && (!emits || !out_valid_r || out_ch.ready);
    below      = (s1_val < lo);
    above      = (s1_val > hi);
    fail       = enabled && s1_idx_ok && (below || above);
    vf_acc     = vf_r | fail;
    check_fire = advance && is_check && enabled;

    elem_nxt = check_fire ? elem_r + COUNT_W'(1) : elem_r;
    vec_nxt  = (check_fire && s1_last) ? vec_r + COUNT_W'(1) : vec_r;
    outl_nxt = (check_fire && s1_last && vf_acc) ? outl_r + COUNT_W'(1) : outl_r;
    vf_nxt   = check_fire ? (s1_last ? 1'b0 : vf_acc) : vf_r;

    wr.lo_we = advance && s1_idx_ok &&
               ((s1_op == OP_LOAD_LO) || ((s1_op == OP_UPDATE) && enabled && below));
    wr.hi_we = advance && s1_idx_ok &&
               ((s1_op == OP_LOAD_HI) || ((s1_op == OP_UPDATE) && enabled && above));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r        <= 1'b0;
      vec_r       <= '0;
      outl_r      <= '0;
      elem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vf_r   <= vf_nxt;
      vec_r  <= vec_nxt;
      outl_r <= outl_nxt;
      elem_r <= elem_nxt;
      if (advance && emits) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance && emits) begin
      in_range_r <= !(enabled && vf_acc);
      vec_out_r  <= vec_nxt;
      outl_out_r <= outl_nxt;
      elem_out_r <= elem_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.in_range         = in_range_r;
  assign out_ch.vectors_checked  = vec_out_r;
  assign out_ch.outlier_vectors  = outl_out_r;
  assign out_ch.elements_checked = elem_out_r;

endmodule

### src/feature_range_outlier_check_core.sv
// Per-feature range checker. Each request carries one Q16.16 value, its
// feature index, an opcode and a last-of-vector mark. Loads write a lower or
// upper bound, an update widens the bounds of one feature when enabled, and a
// check compares the value with its bounds. The last element of a checked
// vector produces one result with the pass flag and wrapping counts of
// vectors, outlier vectors and elements. One request is accepted every clock
// cycle while the output is not stalled; a request is held in the request
// register and its result in the output register. The two bound tables are
// each a one-read, one-write memory with a registered read and a bypass of
// the last write, so an update that follows a request to the same feature
// sees the new bound. The output register lets the next request enter while
// a result waits to be taken. Bounds must be loaded before they are checked
// or updated. The user must see that the enable register is written only
// while no request is in flight; the block itself does not enforce this.
module feature_range_outlier_check_core import frc_pkg::*; #(
  parameter int FEATURES    = FEATURES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  frc_cfg_if.sink   cfg_ch,
  frc_in_if.sink    in_ch,
  frc_out_if.source out_ch
);

  localparam int ADDR_W = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  logic                          enabled_r;
  logic                          s1_valid_r;
  opcode_t                       s1_op_r;
  logic                          s1_last_r;
  logic                          s1_idx_ok_r;
  logic [ADDR_W-1:0]             s1_idx_r;
  logic signed [VALUE_WIDTH-1:0] s1_val_r;

  logic                          advance;
  logic                          accept;
  bound_wr_t                     wr;
  logic [VALUE_WIDTH-1:0]        lo_data, hi_data;
  logic [ADDR_W-1:0]             in_addr;
  logic signed [VALUE_WIDTH-1:0] in_val;
  logic                          in_idx_ok;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      enabled_r <= cfg_ch.enabled;
    end
  end

  assign in_ch.ready = !s1_valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_addr     = ADDR_W'(in_ch.feature_index);
  assign in_val      = VALUE_WIDTH'(in_ch.sample_value);
  assign in_idx_ok   = (32'(in_ch.feature_index) < 32'(FEATURES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
    if (accept) begin
      s1_op_r     <= opcode_t'(in_ch.opcode);
      s1_last_r   <= in_ch.last_element;
      s1_idx_ok_r <= in_idx_ok;
      s1_idx_r    <= in_addr;
      s1_val_r    <= in_val;
    end
  end

  frc_bound_mem #(
    .DEPTH (FEATURES),
    .WIDTH (VALUE_WIDTH)
  ) u_lo_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .wr_en   (wr.lo_we),
    .wr_addr (s1_idx_r),
    .wr_data (s1_val_r),
    .rd_data (lo_data)
  );

  frc_bound_mem #(
    .DEPTH (FEATURES),
    .WIDTH (VALUE_WIDTH)
  ) u_hi_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .wr_en   (wr.hi_we),
    .wr_addr (s1_idx_r),
    .wr_data (s1_val_r),
    .rd_data (hi_data)
  );

  frc_judge #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_judge (
    .clk       (clk),
    .rst_n     (rst_n),
    .enabled   (enabled_r),
    .s1_valid  (s1_valid_r),
    .s1_op     (s1_op_r),
    .s1_last   (s1_last_r),
    .s1_idx_ok (s1_idx_ok_r),
    .s1_val    (s1_val_r),
    .lo        (lo_data),
    .hi        (hi_data),
    .advance   (advance),
    .wr        (wr),
    .out_ch    (out_ch)
  );

endmodule

### src/frc_checker.sv
`include "feature_range_outlier_check_core_defines.svh"

module frc_checker import frc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_in_range,
  input logic [COUNT_W-1:0] out_vectors_checked,
  input logic [COUNT_W-1:0] out_outlier_vectors,
  input logic [COUNT_W-1:0] out_elements_checked
);

  // A waiting result keeps its payload until it is taken.
  `FRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_in_range) && $stable(out_vectors_checked) && $stable(out_outlier_vectors) && $stable(out_elements_checked), "result changed while stalled")

  // With the output register empty, nothing blocks a new request.
  `FRC_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with empty output")

  // A fresh result always comes from an accepted request that has passed the request register and the output register.
  `FRC_ASSERT_NOW(a_result_latency, $rose(out_valid), $past(in_valid && in_ready, 2), "result without matching request")

endmodule

bind feature_range_outlier_check_core frc_checker u_frc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_in_range         (out_ch.in_range),
  .out_vectors_checked  (out_ch.vectors_checked),
  .out_outlier_vectors  (out_ch.outlier_vectors),
  .out_elements_checked (out_ch.elements_checked)
);
